// ----- rtl/pcde_pkg.sv -----
`timescale 1ns / 1ps
package pcde_pkg;

	localparam int NSEG = 17;

	localparam logic [2:0] ACT_LINE   = 3'd0;
	localparam logic [2:0] ACT_SHAPE  = 3'd1;
	localparam logic [2:0] ACT_GLYPH  = 3'd2;
	localparam logic [2:0] ACT_BITMAP = 3'd3;
	localparam logic [2:0] ACT_FINISH = 3'd4;

	localparam logic [7:0] C_END     = 8'd193;
	localparam logic [7:0] C_FONT    = 8'd194;
	localparam logic [7:0] C_EXTENT  = 8'd196;
	localparam logic [7:0] C_SANGLE  = 8'd199;
	localparam logic [7:0] C_EANGLE  = 8'd200;
	localparam logic [7:0] C_MOVE    = 8'd201;
	localparam logic [7:0] C_XMOVE16 = 8'd202;
	localparam logic [7:0] C_YMOVE16 = 8'd203;
	localparam logic [7:0] C_XMOVE8  = 8'd204;
	localparam logic [7:0] C_YMOVE8  = 8'd205;
	localparam logic [7:0] C_PENSIZE = 8'd206;
	localparam logic [7:0] C_CORNER  = 8'd207;
	localparam logic [7:0] C_CAP     = 8'd208;
	localparam logic [7:0] C_LINE    = 8'd209;
	localparam logic [7:0] C_ESC     = 8'd219;
	localparam logic [7:0] C_BITMAP  = 8'd220;
	localparam logic [7:0] C_SHORT_X = 8'd160;

	// Stream segments in the order they appear within any command
	typedef enum logic [4:0] {
		SEG_PEN, SEG_CAP, SEG_MXY, SEG_MX, SEG_MY, SEG_EXT, SEG_CORNER,
		SEG_SANG, SEG_EANG, SEG_LINE, SEG_FONT, SEG_ESC, SEG_CHAR,
		SEG_BMP, SEG_SHAPE, SEG_END, SEG_FULL
	} seg_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_LOAD, ST_SREAD, ST_SCMP, ST_PREP, ST_EMIT
	} state_t;

	typedef struct packed {
		logic       load;
		logic       srch_rd;
		logic       srch_adv;
		logic       found_set;
		logic       commit;
		logic       emit;
		logic       last;
		seg_t       seg;
		logic [2:0] idx;
	} dp_cmd_t;

	typedef struct packed {
		logic            act_ok;
		logic            need_search;
		logic            srch_end;
		logic            srch_hit;
		logic            out_free;
		logic [NSEG-1:0] mask;
		logic [2:0]      seg_len;
	} dp_stat_t;

	function automatic logic [7:0] shape_code(input logic [2:0] kind);
		logic [7:0] c;
		case (kind)
			3'd0: c = 8'd210;
			3'd1: c = 8'd214;
			3'd2: c = 8'd212;
			3'd3: c = 8'd215;
			3'd4: c = 8'd211;
			3'd5: c = 8'd216;
			3'd6: c = 8'd213;
			default: c = 8'd217;
		endcase
		return c;
	endfunction

endpackage

// ----- rtl/pcde_ram.sv -----
`timescale 1ns / 1ps
module pcde_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/pcde_ctrl.sv -----
`timescale 1ns / 1ps
module pcde_ctrl import pcde_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	output logic     cmd_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t     state_q, state_d;
	seg_t       seg_q, seg_d;
	logic [2:0] idx_q, idx_d;
	seg_t       first_seg, next_seg;
	logic       next_found;
	logic       last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seg_q   <= SEG_PEN;
			idx_q   <= 3'd0;
		end else begin
			state_q <= state_d;
			seg_q   <= seg_d;
			idx_q   <= idx_d;
		end
	end

	// lowest nonempty segment, and the lowest one after the current
	always_comb begin
		first_seg  = SEG_FULL;
		next_seg   = SEG_FULL;
		next_found = 1'b0;
		for (int i = NSEG - 1; i >= 0; i--) begin
			if (stat.mask[i]) begin
				first_seg = seg_t'(5'(i));
				if (5'(i) > seg_q) begin
					next_seg   = seg_t'(5'(i));
					next_found = 1'b1;
				end
			end
		end
	end

	assign last_byte = (idx_q == stat.seg_len - 3'd1);

	always_comb begin
		state_d   = state_q;
		seg_d     = seg_q;
		idx_d     = idx_q;
		cmd       = '0;
		cmd.seg   = seg_q;
		cmd.idx   = idx_q;
		cmd_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (!stat.act_ok) begin
					state_d = ST_IDLE;
				end else if (stat.need_search) begin
					state_d = ST_SREAD;
				end else begin
					state_d = ST_PREP;
				end
			end
			ST_SREAD: begin
				if (stat.srch_end) begin
					state_d = ST_PREP;
				end else begin
					cmd.srch_rd = 1'b1;
					state_d     = ST_SCMP;
				end
			end
			ST_SCMP: begin
				if (stat.srch_hit) begin
					cmd.found_set = 1'b1;
					state_d       = ST_PREP;
				end else begin
					cmd.srch_adv = 1'b1;
					state_d      = ST_SREAD;
				end
			end
			ST_PREP: begin
				seg_d   = first_seg;
				idx_d   = 3'd0;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.last = last_byte && !next_found;
					if (!last_byte) begin
						idx_d = idx_q + 3'd1;
					end else if (next_found) begin
						seg_d = next_seg;
						idx_d = 3'd0;
					end else begin
						cmd.commit = (seg_q != SEG_FULL);
						state_d    = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/pcde_dp.sv -----
`timescale 1ns / 1ps
module pcde_dp import pcde_pkg::*; #(
	parameter int FONT_SLOTS   = 16,
	parameter int BITMAP_SLOTS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	output dp_stat_t           stat,
	input  logic [2:0]         action,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic signed [15:0] extent_x,
	input  logic signed [15:0] extent_y,
	input  logic signed [8:0]  pen_size,
	input  logic [7:0]         line_cap,
	input  logic [2:0]         shape_kind,
	input  logic signed [15:0] param_a,
	input  logic signed [15:0] param_b,
	input  logic [15:0]        object_id,
	input  logic               byte_stall,
	output logic               byte_valid,
	output logic [7:0]         out_byte,
	output logic               last,
	output logic               table_full
);

	localparam int FCW = $clog2(FONT_SLOTS + 1);
	localparam int BCW = $clog2(BITMAP_SLOTS + 1);
	localparam int FAW = (FONT_SLOTS > 1) ? $clog2(FONT_SLOTS) : 1;
	localparam int BAW = (BITMAP_SLOTS > 1) ? $clog2(BITMAP_SLOTS) : 1;
	localparam int SW  = (FCW > BCW) ? FCW : BCW;

	// latched command
	logic [2:0]  act_q, kind_q;
	logic [15:0] px_q, py_q, ex_q, ey_q, pa_q, pb_q, key_q;
	logic [8:0]  psz_q;
	logic [7:0]  cap_q;

	// drawing state
	logic [15:0] lpx_q, lpy_q, lex_q, ley_q, lcx_q, lcy_q, lsa_q, lea_q, fkey_q;
	logic [7:0]  lpen_q, lcap_q;
	logic        fvalid_q;
	logic [FCW-1:0] fcount_q;
	logic [BCW-1:0] bcount_q;

	// key search
	logic [SW-1:0] srch_q, fix_q;
	logic          found_q;
	logic [15:0]   font_rd, bmp_rd;

	logic ov_q, ol_q, of_q;
	logic [7:0] ob_q;

	logic is_line, is_shape, is_glyph, is_bmp, is_fin, moves;
	logic need_font, full;
	logic [15:0] dx, dy, rx, ry;
	logic x_short, x_byte, y_byte;
	logic [7:0] font_ix, bmp_ix, ch;
	logic [2:0] len_a [NSEG];
	logic [7:0] seg_bytes [5];
	logic font_we, bmp_we;

	assign is_line  = (act_q == ACT_LINE);
	assign is_shape = (act_q == ACT_SHAPE);
	assign is_glyph = (act_q == ACT_GLYPH);
	assign is_bmp   = (act_q == ACT_BITMAP);
	assign is_fin   = (act_q == ACT_FINISH);
	assign moves    = is_line | is_shape | is_glyph | is_bmp;

	assign need_font = !(fvalid_q && (fkey_q == key_q));
	assign full = (is_glyph && need_font && !found_q && (fcount_q == FCW'(FONT_SLOTS)))
		|| (is_bmp && !found_q && (bcount_q == BCW'(BITMAP_SLOTS)));

	assign dx = px_q - lpx_q;
	assign dy = py_q - lpy_q;
	assign rx = ex_q - px_q;
	assign ry = ey_q - py_q;
	assign x_short = (&dx[15:5]) | ~(|dx[15:5]);
	assign x_byte  = (&dx[15:7]) | ~(|dx[15:7]);
	assign y_byte  = (&dy[15:7]) | ~(|dy[15:7]);
	assign ch      = pa_q[7:0];
	assign font_ix = found_q ? 8'(fix_q) : 8'(fcount_q);
	assign bmp_ix  = found_q ? 8'(fix_q) : 8'(bcount_q);

	// segment lengths; a full table leaves only the error result
	always_comb begin
		for (int i = 0; i < NSEG; i++) begin
			len_a[i] = 3'd0;
		end
		if (full) begin
			len_a[SEG_FULL] = 3'd1;
		end else begin
			if ((is_line && psz_q[7:0] != lpen_q)
				|| (is_shape && !psz_q[8] && psz_q[7:0] != lpen_q)) begin
				len_a[SEG_PEN] = 3'd2;
			end
			if (is_line && cap_q != lcap_q) begin
				len_a[SEG_CAP] = 3'd2;
			end
			if (moves && dx != 16'd0 && dy != 16'd0) begin
				len_a[SEG_MXY] = 3'd5;
			end
			if (moves && dx != 16'd0 && dy == 16'd0) begin
				len_a[SEG_MX] = x_short ? 3'd1 : (x_byte ? 3'd2 : 3'd3);
			end
			if (moves && dy != 16'd0 && dx == 16'd0) begin
				len_a[SEG_MY] = y_byte ? 3'd2 : 3'd3;
			end
			if ((is_shape || is_bmp) && (ex_q != lex_q || ey_q != ley_q)) begin
				len_a[SEG_EXT] = 3'd5;
			end
			if (is_shape && kind_q[2:1] == 2'b10 && (pa_q != lcx_q || pb_q != lcy_q)) begin
				len_a[SEG_CORNER] = 3'd5;
			end
			if (is_shape && kind_q[2:1] == 2'b11 && pa_q != lsa_q) begin
				len_a[SEG_SANG] = 3'd3;
			end
			if (is_shape && kind_q[2:1] == 2'b11 && pb_q != lea_q) begin
				len_a[SEG_EANG] = 3'd3;
			end
			if (is_line) begin
				len_a[SEG_LINE] = 3'd5;
			end
			if (is_glyph && need_font) begin
				len_a[SEG_FONT] = 3'd2;
			end
			if (is_glyph && ch[7]) begin
				len_a[SEG_ESC] = 3'd1;
			end
			if (is_glyph) begin
				len_a[SEG_CHAR] = 3'd1;
			end
			if (is_bmp) begin
				len_a[SEG_BMP] = 3'd2;
			end
			if (is_shape) begin
				len_a[SEG_SHAPE] = 3'd1;
			end
			if (is_fin) begin
				len_a[SEG_END] = 3'd1;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 5; i++) begin
			seg_bytes[i] = 8'd0;
		end
		case (cmd.seg)
			SEG_PEN: begin
				seg_bytes[0] = C_PENSIZE;
				seg_bytes[1] = psz_q[7:0];
			end
			SEG_CAP: begin
				seg_bytes[0] = C_CAP;
				seg_bytes[1] = cap_q;
			end
			SEG_MXY: begin
				seg_bytes[0] = C_MOVE;
				seg_bytes[1] = dx[15:8];
				seg_bytes[2] = dx[7:0];
				seg_bytes[3] = dy[15:8];
				seg_bytes[4] = dy[7:0];
			end
			SEG_MX: begin
				if (x_short) begin
					seg_bytes[0] = C_SHORT_X + dx[7:0];
				end else if (x_byte) begin
					seg_bytes[0] = C_XMOVE8;
					seg_bytes[1] = dx[7:0];
				end else begin
					seg_bytes[0] = C_XMOVE16;
					seg_bytes[1] = dx[15:8];
					seg_bytes[2] = dx[7:0];
				end
			end
			SEG_MY: begin
				if (y_byte) begin
					seg_bytes[0] = C_YMOVE8;
					seg_bytes[1] = dy[7:0];
				end else begin
					seg_bytes[0] = C_YMOVE16;
					seg_bytes[1] = dy[15:8];
					seg_bytes[2] = dy[7:0];
				end
			end
			SEG_EXT: begin
				seg_bytes[0] = C_EXTENT;
				seg_bytes[1] = ex_q[15:8];
				seg_bytes[2] = ex_q[7:0];
				seg_bytes[3] = ey_q[15:8];
				seg_bytes[4] = ey_q[7:0];
			end
			SEG_CORNER: begin
				seg_bytes[0] = C_CORNER;
				seg_bytes[1] = pa_q[15:8];
				seg_bytes[2] = pa_q[7:0];
				seg_bytes[3] = pb_q[15:8];
				seg_bytes[4] = pb_q[7:0];
			end
			SEG_SANG: begin
				seg_bytes[0] = C_SANGLE;
				seg_bytes[1] = pa_q[15:8];
				seg_bytes[2] = pa_q[7:0];
			end
			SEG_EANG: begin
				seg_bytes[0] = C_EANGLE;
				seg_bytes[1] = pb_q[15:8];
				seg_bytes[2] = pb_q[7:0];
			end
			SEG_LINE: begin
				seg_bytes[0] = C_LINE;
				seg_bytes[1] = rx[15:8];
				seg_bytes[2] = rx[7:0];
				seg_bytes[3] = ry[15:8];
				seg_bytes[4] = ry[7:0];
			end
			SEG_FONT: begin
				seg_bytes[0] = C_FONT;
				seg_bytes[1] = font_ix;
			end
			SEG_ESC:   seg_bytes[0] = C_ESC;
			SEG_CHAR:  seg_bytes[0] = ch;
			SEG_BMP: begin
				seg_bytes[0] = C_BITMAP;
				seg_bytes[1] = bmp_ix;
			end
			SEG_SHAPE: seg_bytes[0] = shape_code(kind_q);
			SEG_END:   seg_bytes[0] = C_END;
			default:   seg_bytes[0] = 8'd0;
		endcase
	end

	always_comb begin
		stat.act_ok      = moves | is_fin;
		stat.need_search = is_bmp || (is_glyph && need_font);
		stat.srch_end    = is_glyph ? (srch_q >= SW'(fcount_q)) : (srch_q >= SW'(bcount_q));
		stat.srch_hit    = (is_glyph ? font_rd : bmp_rd) == key_q;
		stat.out_free    = !ov_q || !byte_stall;
		stat.seg_len     = len_a[cmd.seg];
		for (int i = 0; i < NSEG; i++) begin
			stat.mask[i] = (len_a[i] != 3'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q  <= action;
			px_q   <= pos_x;
			py_q   <= pos_y;
			ex_q   <= extent_x;
			ey_q   <= extent_y;
			psz_q  <= pen_size;
			cap_q  <= line_cap;
			kind_q <= shape_kind;
			pa_q   <= param_a;
			pb_q   <= param_b;
			key_q  <= object_id;
		end
		if (cmd.found_set) begin
			fix_q <= srch_q;
		end
		if (cmd.emit) begin
			ob_q <= seg_bytes[cmd.idx];
			ol_q <= cmd.last;
			of_q <= (cmd.seg == SEG_FULL);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lpx_q    <= '0;
			lpy_q    <= '0;
			lex_q    <= '0;
			ley_q    <= '0;
			lcx_q    <= '0;
			lcy_q    <= '0;
			lsa_q    <= '0;
			lea_q    <= '0;
			lpen_q   <= 8'd1;
			lcap_q   <= '0;
			fkey_q   <= '0;
			fvalid_q <= 1'b0;
			fcount_q <= '0;
			bcount_q <= '0;
			srch_q   <= '0;
			found_q  <= 1'b0;
			ov_q     <= 1'b0;
		end else begin
			if (cmd.load) begin
				srch_q  <= '0;
				found_q <= 1'b0;
			end else if (cmd.srch_adv) begin
				srch_q <= srch_q + SW'(1);
			end
			if (cmd.found_set) begin
				found_q <= 1'b1;
			end
			if (cmd.emit) begin
				ov_q <= 1'b1;
			end else if (!byte_stall) begin
				ov_q <= 1'b0;
			end
			if (cmd.commit) begin
				if (is_line || (is_shape && !psz_q[8])) begin
					lpen_q <= psz_q[7:0];
				end
				if (is_line) begin
					lcap_q <= cap_q;
					lpx_q  <= ex_q;
					lpy_q  <= ey_q;
				end
				if (is_shape || is_bmp) begin
					lpx_q <= px_q;
					lpy_q <= py_q;
					lex_q <= ex_q;
					ley_q <= ey_q;
				end
				if (is_shape && kind_q[2:1] == 2'b10) begin
					lcx_q <= pa_q;
					lcy_q <= pb_q;
				end
				if (is_shape && kind_q[2:1] == 2'b11) begin
					lsa_q <= pa_q;
					lea_q <= pb_q;
				end
				if (is_glyph) begin
					lpx_q    <= px_q + pb_q;
					lpy_q    <= py_q;
					fkey_q   <= key_q;
					fvalid_q <= 1'b1;
				end
				if (font_we) begin
					fcount_q <= fcount_q + FCW'(1);
				end
				if (bmp_we) begin
					bcount_q <= bcount_q + BCW'(1);
				end
			end
		end
	end

	assign font_we = cmd.commit && is_glyph && need_font && !found_q;
	assign bmp_we  = cmd.commit && is_bmp && !found_q;

	pcde_ram #(.WIDTH(16), .DEPTH(FONT_SLOTS)) u_font_ram (
		.clk   (clk),
		.we    (font_we),
		.waddr (fcount_q[FAW-1:0]),
		.wdata (key_q),
		.re    (cmd.srch_rd && is_glyph),
		.raddr (srch_q[FAW-1:0]),
		.rdata (font_rd)
	);

	pcde_ram #(.WIDTH(16), .DEPTH(BITMAP_SLOTS)) u_bmp_ram (
		.clk   (clk),
		.we    (bmp_we),
		.waddr (bcount_q[BAW-1:0]),
		.wdata (key_q),
		.re    (cmd.srch_rd && is_bmp),
		.raddr (srch_q[BAW-1:0]),
		.rdata (bmp_rd)
	);

	assign byte_valid = ov_q;
	assign out_byte   = ob_q;
	assign last       = ol_q;
	assign table_full = of_q;

endmodule

// ----- rtl/picture_command_delta_encoder.sv -----
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// command   cmd_valid / cmd_stall   action .. object_id, one drawing command
// stream    byte_valid / byte_stall out_byte, last, table_full, one byte
//
// A command passes accept, load and setup; a glyph with a new font or a
// bitmap adds a search of its key table (shared key search over a
// registered-read RAM, a read then a compare per entry), which ends at the
// fill count when the key is not found; then bytes are emitted, one per cycle
// while the stream does not stall. An ignored action code returns to idle
// after load. One output register carries the stream; a stall there holds
// the byte emitter. cmd_stall is high while a command is in flight.
// Reset clears all drawing state and the table fill counts; the key tables
// need no clearing pass since entries are only read below the fill count.
module picture_command_delta_encoder import pcde_pkg::*; #(
	parameter int FONT_SLOTS   = 16,
	parameter int BITMAP_SLOTS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  logic [2:0]         action,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic signed [15:0] extent_x,
	input  logic signed [15:0] extent_y,
	input  logic signed [8:0]  pen_size,
	input  logic [7:0]         line_cap,
	input  logic [2:0]         shape_kind,
	input  logic signed [15:0] param_a,
	input  logic signed [15:0] param_b,
	input  logic [15:0]        object_id,
	output logic               byte_valid,
	input  logic               byte_stall,
	output logic [7:0]         out_byte,
	output logic               last,
	output logic               table_full
);

	// controller sequences load, key search and segment emission;
	// datapath holds the command, drawing state, tables and output register
	dp_cmd_t  cmd;
	dp_stat_t stat;

	pcde_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	pcde_dp #(
		.FONT_SLOTS   (FONT_SLOTS),
		.BITMAP_SLOTS (BITMAP_SLOTS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.action     (action),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.extent_x   (extent_x),
		.extent_y   (extent_y),
		.pen_size   (pen_size),
		.line_cap   (line_cap),
		.shape_kind (shape_kind),
		.param_a    (param_a),
		.param_b    (param_b),
		.object_id  (object_id),
		.byte_stall (byte_stall),
		.byte_valid (byte_valid),
		.out_byte   (out_byte),
		.last       (last),
		.table_full (table_full)
	);

	// a table-full error is a lone zero byte that closes the command
	a_full_alone: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && table_full |-> last && out_byte == 8'd0)
		else $error("table_full result malformed");

	// an accepted command always holds off the next one
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("command channel not held after accept");

	// a table-full result never comes alongside a command commit
	a_no_commit_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> cmd.seg != SEG_FULL)
		else $error("state committed on table-full command");

endmodule

// ----- verif/picture_command_delta_encoder_test.sv -----
`timescale 1ns / 1ps
module picture_command_delta_encoder_test;
	import pcde_pkg::*;

	localparam int FONT_CAP   = 16;
	localparam int BITMAP_CAP = 64;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cmd_valid = 1'b0;
	logic               cmd_stall;
	logic [2:0]         action = '0;
	logic signed [15:0] pos_x = '0, pos_y = '0, extent_x = '0, extent_y = '0;
	logic signed [8:0]  pen_size = '0;
	logic [7:0]         line_cap = '0;
	logic [2:0]         shape_kind = '0;
	logic signed [15:0] param_a = '0, param_b = '0;
	logic [15:0]        object_id = '0;
	logic               byte_valid;
	logic               byte_stall = 1'b0;
	logic [7:0]         out_byte;
	logic               last;
	logic               table_full;

	picture_command_delta_encoder i_dut (.*);

	always #4 clk = ~clk;

	// One drawing command as the sender sees it
	typedef struct {
		logic [2:0]  act;
		logic [15:0] px, py, ex, ey;
		logic [8:0]  psz;
		logic [7:0]  cap;
		logic [2:0]  kind;
		logic [15:0] pa, pb, key;
	} draw_cmd_t;

	// One expected stream byte with its flags
	typedef struct {
		logic [7:0] b;
		logic       lst;
		logic       full;
	} stream_byte_t;

	stream_byte_t pending_bytes[$];
	int           mismatches = 0;
	int           bytes_seen = 0;
	int           cmds_sent = 0;
	int           full_seen = 0;

	// Shadow copy of the encoder state
	logic [15:0] sh_px, sh_py, sh_ex, sh_ey, sh_cx, sh_cy, sh_sa, sh_ea;
	logic [7:0]  sh_pen, sh_cap;
	logic [15:0] sh_font_key;
	logic        sh_font_ok;
	int          sh_font_n, sh_bmp_n;
	logic [15:0] sh_fonts[FONT_CAP];
	logic [15:0] sh_bmps[BITMAP_CAP];
	logic [7:0]  enc_buf[$];

	// Frequent stalls on the stream side, set by the drain-pause test
	bit slow_sink = 1'b0;

	function automatic void shadow_clear();
		{sh_px, sh_py, sh_ex, sh_ey, sh_cx, sh_cy, sh_sa, sh_ea} = '0;
		sh_pen = 8'd1;
		sh_cap = 8'd0;
		sh_font_key = '0;
		sh_font_ok = 1'b0;
		sh_font_n = 0;
		sh_bmp_n = 0;
	endfunction

	function automatic void emit_short(logic [15:0] v);
		enc_buf.push_back(v[15:8]);
		enc_buf.push_back(v[7:0]);
	endfunction

	function automatic void encode_move(logic [15:0] x, logic [15:0] y);
		logic [15:0] dx, dy;
		int sdx, sdy;
		dx = x - sh_px;
		dy = y - sh_py;
		sdx = $signed(dx);
		sdy = $signed(dy);
		sh_px = x;
		sh_py = y;
		if (dx != 0 && dy != 0) begin
			enc_buf.push_back(C_MOVE);
			emit_short(dx);
			emit_short(dy);
			return;
		end
		if (dx != 0) begin
			if (sdx >= -32 && sdx < 32)
				enc_buf.push_back(8'(int'(C_SHORT_X) + sdx));
			else if (sdx >= -128 && sdx < 128) begin
				enc_buf.push_back(C_XMOVE8);
				enc_buf.push_back(dx[7:0]);
			end else begin
				enc_buf.push_back(C_XMOVE16);
				emit_short(dx);
			end
		end
		if (dy != 0) begin
			if (sdy >= -128 && sdy < 128) begin
				enc_buf.push_back(C_YMOVE8);
				enc_buf.push_back(dy[7:0]);
			end else begin
				enc_buf.push_back(C_YMOVE16);
				emit_short(dy);
			end
		end
	endfunction

	function automatic void encode_pen(logic [7:0] s);
		if (s != sh_pen) begin
			enc_buf.push_back(C_PENSIZE);
			enc_buf.push_back(s);
			sh_pen = s;
		end
	endfunction

	function automatic void encode_extent(logic [15:0] ex, logic [15:0] ey);
		if (ex != sh_ex || ey != sh_ey) begin
			enc_buf.push_back(C_EXTENT);
			emit_short(ex);
			emit_short(ey);
			sh_ex = ex;
			sh_ey = ey;
		end
	endfunction

	// Encode one command into the expected byte queue
	function automatic void encode_command(draw_cmd_t c);
		logic [15:0] rx, ry;
		logic [7:0]  ch;
		bit          need_font, full;
		int          ix;
		stream_byte_t sb;
		enc_buf.delete();
		full = 1'b0;
		case (c.act)
			ACT_LINE: begin
				rx = c.ex - c.px;
				ry = c.ey - c.py;
				encode_pen(c.psz[7:0]);
				if (c.cap != sh_cap) begin
					enc_buf.push_back(C_CAP);
					enc_buf.push_back(c.cap);
					sh_cap = c.cap;
				end
				encode_move(c.px, c.py);
				enc_buf.push_back(C_LINE);
				emit_short(rx);
				emit_short(ry);
				sh_px += rx;
				sh_py += ry;
			end
			ACT_SHAPE: begin
				if (!c.psz[8]) encode_pen(c.psz[7:0]);
				encode_move(c.px, c.py);
				encode_extent(c.ex, c.ey);
				if (c.kind == 3'd4 || c.kind == 3'd5) begin
					if (c.pa != sh_cx || c.pb != sh_cy) begin
						enc_buf.push_back(C_CORNER);
						emit_short(c.pa);
						emit_short(c.pb);
						sh_cx = c.pa;
						sh_cy = c.pb;
					end
				end else if (c.kind >= 3'd6) begin
					if (c.pa != sh_sa) begin
						enc_buf.push_back(C_SANGLE);
						emit_short(c.pa);
						sh_sa = c.pa;
					end
					if (c.pb != sh_ea) begin
						enc_buf.push_back(C_EANGLE);
						emit_short(c.pb);
						sh_ea = c.pb;
					end
				end
				case (c.kind)
					3'd0: enc_buf.push_back(8'd210);
					3'd1: enc_buf.push_back(8'd214);
					3'd2: enc_buf.push_back(8'd212);
					3'd3: enc_buf.push_back(8'd215);
					3'd4: enc_buf.push_back(8'd211);
					3'd5: enc_buf.push_back(8'd216);
					3'd6: enc_buf.push_back(8'd213);
					default: enc_buf.push_back(8'd217);
				endcase
			end
			ACT_GLYPH: begin
				ch = c.pa[7:0];
				need_font = !(sh_font_ok && sh_font_key == c.key);
				ix = -1;
				if (need_font)
					for (int i = 0; i < sh_font_n; i++)
						if (ix < 0 && sh_fonts[i] == c.key) ix = i;
				if (need_font && ix < 0 && sh_font_n >= FONT_CAP)
					full = 1'b1;
				else begin
					encode_move(c.px, c.py);
					if (need_font) begin
						if (ix < 0) begin
							ix = sh_font_n;
							sh_fonts[sh_font_n] = c.key;
							sh_font_n++;
						end
						sh_font_key = c.key;
						sh_font_ok = 1'b1;
						enc_buf.push_back(C_FONT);
						enc_buf.push_back(8'(ix));
					end
					if (ch >= 8'd128) enc_buf.push_back(C_ESC);
					enc_buf.push_back(ch);
					sh_px += c.pb;
				end
			end
			ACT_BITMAP: begin
				ix = -1;
				for (int i = 0; i < sh_bmp_n; i++)
					if (ix < 0 && sh_bmps[i] == c.key) ix = i;
				if (ix < 0 && sh_bmp_n >= BITMAP_CAP)
					full = 1'b1;
				else begin
					encode_move(c.px, c.py);
					encode_extent(c.ex, c.ey);
					enc_buf.push_back(C_BITMAP);
					if (ix < 0) begin
						ix = sh_bmp_n;
						sh_bmps[sh_bmp_n] = c.key;
						sh_bmp_n++;
					end
					enc_buf.push_back(8'(ix));
				end
			end
			ACT_FINISH: enc_buf.push_back(C_END);
			default: ;
		endcase
		if (full) begin
			sb = '{8'd0, 1'b1, 1'b1};
			pending_bytes.push_back(sb);
		end else
			foreach (enc_buf[i]) begin
				sb = '{enc_buf[i], i == enc_buf.size() - 1, 1'b0};
				pending_bytes.push_back(sb);
			end
	endfunction

	task automatic report_mismatch(string what);
		mismatches++;
		$display("mismatch at %0t: %s", $time, what);
	endtask

	// Send one command: random gap, then hold until accepted
	task automatic send_command(draw_cmd_t c);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) gap = 0;
		repeat (gap) @(negedge clk);
		action = c.act; pos_x = c.px; pos_y = c.py;
		extent_x = c.ex; extent_y = c.ey; pen_size = c.psz;
		line_cap = c.cap; shape_kind = c.kind;
		param_a = c.pa; param_b = c.pb; object_id = c.key;
		cmd_valid = 1'b1;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		encode_command(c);
		cmds_sent++;
		@(negedge clk);
		cmd_valid = 1'b0;
	endtask

	// Random stall on the stream side
	always @(negedge clk) begin
		if (slow_sink)
			byte_stall <= ($urandom_range(0, 3) != 0);
		else if ($urandom_range(0, 40) == 0)
			byte_stall <= 1'b1;
		else
			byte_stall <= ($urandom_range(0, 4) == 0);
	end

	// Compare each accepted byte with the oldest expectation
	always @(posedge clk) begin
		stream_byte_t e;
		if (arst_n && byte_valid && !byte_stall) begin
			bytes_seen++;
			if (pending_bytes.size() == 0)
				report_mismatch($sformatf("unexpected byte %0d", out_byte));
			else begin
				e = pending_bytes.pop_front();
				if (out_byte !== e.b)
					report_mismatch($sformatf("out_byte %0d, want %0d", out_byte, e.b));
				if (last !== e.lst)
					report_mismatch($sformatf("last %b, want %b", last, e.lst));
				if (table_full !== e.full)
					report_mismatch($sformatf("table_full %b, want %b", table_full, e.full));
				if (e.full) full_seen++;
			end
		end
	end

	function automatic logic [15:0] rand_coord();
		case ($urandom_range(0, 4))
			0: return 16'($urandom_range(0, 40)) - 16'd20;
			1: return 16'($urandom_range(0, 300)) - 16'd150;
			2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic draw_cmd_t rand_command(int key_span);
		draw_cmd_t c;
		c.act = ($urandom_range(0, 30) == 0) ? 3'($urandom_range(5, 7))
			: 3'($urandom_range(0, 4));
		c.px = rand_coord(); c.py = $urandom_range(0, 2) ? sh_py : rand_coord();
		c.ex = rand_coord(); c.ey = rand_coord();
		if ($urandom_range(0, 2) == 0) begin
			c.ex = sh_ex; c.ey = sh_ey;
		end
		c.psz = $urandom_range(0, 3) == 0 ? 9'($urandom) : 9'($urandom_range(1, 3));
		c.cap = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 2));
		c.kind = 3'($urandom);
		c.pa = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 3));
		c.pb = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 3));
		c.key = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, key_span));
		return c;
	endfunction

	function automatic draw_cmd_t blank_command(logic [2:0] act);
		draw_cmd_t c;
		c = '{act, 16'd0, 16'd0, 16'd0, 16'd0, 9'd1, 8'd0, 3'd0, 16'd0, 16'd0, 16'd0};
		return c;
	endfunction

	// Field extremes, every shape, each move form but the byte y move
	task automatic test_directed();
		draw_cmd_t c;
		int        steps[6] = '{-32, 31, 32, -128, 127, 128};
		c = blank_command(ACT_LINE);
		c.px = 16'h7fff; c.py = 16'h8000; c.ex = 16'h8000; c.ey = 16'h7fff;
		c.psz = 9'h0ff; c.cap = 8'hff;
		send_command(c);
		c = blank_command(ACT_LINE);
		c.psz = 9'h100; c.cap = 8'h00;   // line uses low pen bits only
		send_command(c);
		for (int k = 0; k < 8; k++) begin
			c = blank_command(ACT_SHAPE);
			c.kind = 3'(k);
			c.px = 16'(k * 5); c.ex = 16'(k); c.ey = 16'hffff;
			c.pa = (k % 2) ? 16'h8000 : 16'h7fff; c.pb = 16'(k);
			c.psz = (k == 3) ? 9'h1ff : 9'(k);   // negative keeps pen
			send_command(c);
		end
		// Short x, byte x and word x moves, then a word y move
		foreach (steps[i]) begin
			c = blank_command(ACT_SHAPE);
			c.px = 16'(int'(sh_px) + steps[i]);
			c.py = sh_py; c.ex = sh_ex; c.ey = sh_ey; c.psz = 9'h1ff;
			send_command(c);
		end
		c = blank_command(ACT_SHAPE);
		c.px = sh_px; c.py = sh_py + 16'd300; c.psz = 9'h1ff;
		send_command(c);
		c = blank_command(ACT_GLYPH);
		c.pa = 16'h0041; c.pb = 16'd7; c.key = 16'hffff;
		send_command(c);
		c.pa = 16'hff80; c.px = 16'h1234;   // escaped code, font already current
		send_command(c);
		c = blank_command(ACT_BITMAP);
		c.key = 16'hffff; c.ex = 16'h8000;
		send_command(c);
		send_command(c);
		send_command(blank_command(ACT_FINISH));
		send_command(blank_command(3'd7));   // ignored action
	endtask

	// Fill both key tables, then overflow them
	task automatic test_table_full();
		draw_cmd_t c;
		for (int k = 0; k < FONT_CAP + 3; k++) begin
			c = blank_command(ACT_GLYPH);
			c.key = 16'(16'h100 + k); c.pa = 16'(k * 9); c.px = 16'($urandom);
			send_command(c);
		end
		c.key = 16'h0100;                    // old font, found in the table
		send_command(c);
		for (int k = 0; k < BITMAP_CAP + 3; k++) begin
			c = blank_command(ACT_BITMAP);
			c.key = 16'(16'h200 + k); c.px = 16'($urandom);
			send_command(c);
		end
		c.key = 16'h0200;
		send_command(c);
	endtask

	// Hold off the sender until the stream drains, under a slow sink
	task automatic test_drain_pause();
		slow_sink = 1'b1;
		for (int k = 0; k < 10; k++) send_command(rand_command(20));
		while (pending_bytes.size() != 0) @(negedge clk);
		slow_sink = 1'b0;
	endtask

	task automatic test_random();
		for (int k = 0; k < 200; k++) send_command(rand_command(k < 100 ? 10 : 300));
	endtask

	initial begin
		#10000000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		shadow_clear();
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_drain_pause();
		test_table_full();
		test_random();
		while (pending_bytes.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		$display("covered %0d commands, %0d stream bytes, %0d table-full results",
			cmds_sent, bytes_seen, full_seen);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- picture_command_delta_encoder.f -----
rtl/pcde_pkg.sv
rtl/pcde_ram.sv
rtl/pcde_ctrl.sv
rtl/pcde_dp.sv
rtl/picture_command_delta_encoder.sv
verif/picture_command_delta_encoder_test.sv
